// File: hdl/s2da_pkg.sv
// Package for the signed binary to decimal ASCII converter.
// Holds widths, character codes, the controller state type and the cell control word.
// No dependencies.
`default_nettype none

package s2da_pkg;

   localparam int MagWidth   = 32;
   localparam int NumDigits  = 10;
   localparam int DigitWidth = 4;
   localparam int CharWidth  = 7;
   localparam int StepWidth  = $clog2(MagWidth);
   localparam int CountWidth = $clog2(NumDigits + 1);

   localparam logic [CharWidth-1:0] MinusChar = 7'd45;
   localparam logic [CharWidth-1:0] ZeroChar  = 7'd48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/s2da_channels.sv
// Handshake channel interfaces for the converter's input and result words.
// Depends on s2da_pkg for the payload widths.
`default_nettype none

interface s2da_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [s2da_pkg::MagWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface s2da_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [s2da_pkg::CharWidth-1:0]   character;
   logic                             last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, one character per word, last flagged.
// It accepts the number, runs shift-and-add-3 through ten BCD cells, drops leading zeros,
// then sends one character per cycle (up to 11) while the output does not stall.
// One number at a time: a new number is accepted only once the controller is back in idle.
// Synchronous active-high reset returns the controller to idle with no word pending.
// Depends on s2da_pkg, s2da_channels and s2da_bcd_cell.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
   input  logic       clock,
   input  logic       reset,
   s2da_req_if.sink   req_chan,
   s2da_rsp_if.source rsp_chan
);
   import s2da_pkg::*;

   state_type state_ff, state_in;

   logic [MagWidth-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         cell_ctrl;
   logic [NumDigits:0]    carry_chain;
   logic [DigitWidth-1:0] digits [NumDigits+1];
   logic [DigitWidth-1:0] top_digit;
   logic                  accept;
   logic                  load_ok;
   logic [MagWidth-1:0]   raw;

   assign carry_chain[0] = mag_ff[MagWidth-1];
   assign digits[0]      = '0;
   assign top_digit      = digits[NumDigits];

   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      s2da_bcd_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .shift_bit   (carry_chain[i]),
         .lower_digit (digits[i]),
         .carry_bit   (carry_chain[i+1]),
         .digit       (digits[i+1])
      );
   end

   assign raw     = req_chan.value;
   assign accept  = req_chan.valid && (state_ff == ST_IDLE);
   assign load_ok = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (step_ff == StepWidth'(MagWidth - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!(top_digit == '0 && count_ff > CountWidth'(1))) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (load_ok) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (load_ok && count_ff == CountWidth'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      cell_ctrl      = '0;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in          = raw[MagWidth-1];
               mag_in          = raw[MagWidth-1] ? (~raw + MagWidth'(1)) : raw;
               step_in         = '0;
               cell_ctrl.clear = 1'b1;
            end
         end
         ST_CONVERT: begin
            cell_ctrl.dabble = 1'b1;
            mag_in           = {mag_ff[MagWidth-2:0], 1'b0};
            step_in          = step_ff + StepWidth'(1);
            count_in         = CountWidth'(NumDigits);
         end
         ST_SKIP: begin
            if (top_digit == '0 && count_ff > CountWidth'(1)) begin
               cell_ctrl.shift = 1'b1;
               count_in        = count_ff - CountWidth'(1);
            end
         end
         ST_SIGN: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = MinusChar;
               rsp_last_in  = 1'b0;
            end
         end
         ST_DIGITS: begin
            if (load_ok) begin
               rsp_valid_in    = 1'b1;
               rsp_char_in     = ZeroChar + CharWidth'(top_digit);
               rsp_last_in     = (count_ff == CountWidth'(1));
               cell_ctrl.shift = 1'b1;
               count_in        = count_ff - CountWidth'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

`default_nettype wire

// File: hdl/s2da_bcd_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on s2da_pkg for the digit width and the cell control word.
`default_nettype none

module s2da_bcd_cell (
   input  logic                             clock,
   input  s2da_pkg::cell_ctrl_type          ctrl,
   input  logic                             shift_bit,
   input  logic [s2da_pkg::DigitWidth-1:0]  lower_digit,
   output logic                             carry_bit,
   output logic [s2da_pkg::DigitWidth-1:0]  digit
);
   import s2da_pkg::*;

   logic [DigitWidth-1:0] digit_ff;
   logic [DigitWidth-1:0] digit_in;
   logic [DigitWidth-1:0] adjusted;

   always_comb begin
      adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
      carry_bit = adjusted[DigitWidth-1];
      digit_in  = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[DigitWidth-2:0], shift_bit};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for signed_int_to_decimal_ascii_unit: random and directed numbers go in, and
// each character word that comes out is checked against a predicted decimal text.
// Depends on s2da_pkg, s2da_channels and the converter RTL.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s2da_pkg::*;

   localparam int StallLimit = 2000;
   localparam int SettleCycles = 60;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } char_word_type;

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int stall_cycles;

   char_word_type expected_chars[$];

   s2da_req_if req_chan ();
   s2da_rsp_if rsp_chan ();

   signed_int_to_decimal_ascii_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5ns clock = ~clock;

   // Queues the characters of the decimal text of one number, sign first.
   function automatic void predict_text(input logic signed [MagWidth-1:0] number);
      logic [MagWidth-1:0]   mag;
      logic [DigitWidth-1:0] digits[NumDigits];
      char_word_type         word;
      int                    count;
      mag = number[MagWidth-1] ? (~number + 1'b1) : number;
      count = 0;
      do begin
         digits[count] = DigitWidth'(mag % 10);
         mag = mag / 10;
         count++;
      end while (mag != 0 && count < NumDigits);
      if (number[MagWidth-1]) begin
         word.character = MinusChar;
         word.last = 1'b0;
         expected_chars.push_back(word);
      end
      for (int i = count - 1; i >= 0; i--) begin
         word.character = ZeroChar + CharWidth'(digits[i]);
         word.last = (i == 0);
         expected_chars.push_back(word);
      end
   endfunction

   function automatic logic signed [MagWidth-1:0] pick_value();
      logic [MagWidth-1:0] mag;
      logic [MagWidth-1:0] tens;
      int                  k;
      case ($urandom_range(3))
         0: begin
            return $urandom;
         end
         1: begin
            mag = $urandom >> $urandom_range(31);
         end
         2: begin
            mag = $urandom_range(99);
         end
         default: begin
            tens = 1;
            k = $urandom_range(9);
            repeat (k) tens = tens * 10;
            mag = tens - 1 + $urandom_range(2);
         end
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   task automatic send_value(input logic signed [MagWidth-1:0] number);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= number;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_text(number);
   endtask

   task automatic test_directed();
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(10);
      send_value(-10);
      send_value(100);
      send_value(-7);
      send_value(12345);
      send_value(999999999);
      send_value(1000000000);
      send_value(-1000000000);
      send_value(32'sh7FFFFFFF);
      send_value(32'sh80000000);
      send_value(32'sh80000001);
      send_value(32'sh55555555);
      send_value(32'shAAAAAAAA);
      send_value(32'sh0000FFFF);
      send_value(32'shFFFF0000);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_value(pick_value());
   endtask

   // The sender holds off until the last character of the previous number is out.
   task automatic test_drain_between_numbers();
      repeat (4) begin
         send_value(pick_value());
         req_chan.valid <= 1'b0;
         while (expected_chars.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      char_word_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual character %0d last %0b",
                        $time, rsp_chan.character, rsp_chan.last);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_chan.character !== want.character) begin
                  $display("%0t: character mismatch: expected %0d, actual %0d",
                           $time, want.character, rsp_chan.character);
                  mismatch_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_chan.last);
                  mismatch_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      send_idle_pct = 33;
      recv_idle_pct = 58;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(60);

      send_idle_pct = 58;
      recv_idle_pct = 33;
      test_random(60);
      test_drain_between_numbers();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(50);

      req_chan.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
